[src/smcn_pkg.sv]
//------------------------------------------------------------------------------
// smcn_pkg
// Shared types and constants for the sensor min/max calibration block.
//------------------------------------------------------------------------------
`default_nettype none

package smcn_pkg;

   localparam int DATA_W      = 16;
   localparam int CH_W        = 4;
   localparam int CSR_INDEX_W = 2;
   localparam int QUEUE_DEPTH = 2;
   localparam int PAIR_W      = 2 * DATA_W;

   localparam logic [DATA_W-1:0] MIN_RESET = '1;
   localparam logic [DATA_W-1:0] MAX_RESET = '0;
   localparam logic [DATA_W-1:0] FULL_SCALE_RESET = 16'd1000;

   localparam logic [CSR_INDEX_W-1:0] CSR_FULL_SCALE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INVERT     = 2'd1;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_TRACK = 2'd1,
      OP_NORM  = 2'd2,
      OP_LOAD  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      KIND_ZERO = 2'd0,
      KIND_LOW  = 2'd1,
      KIND_HIGH = 2'd2,
      KIND_DIV  = 2'd3
   } kind_type;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_READ = 5'b00010,
      S_MUL  = 5'b00100,
      S_DIV  = 5'b01000,
      S_DONE = 5'b10000
   } state_type;

   typedef struct packed {
      op_type              op;
      logic                ch_ok;
      logic [CH_W-1:0]     channel;
      logic [DATA_W-1:0]   raw;
      logic [DATA_W-1:0]   smin;
      logic [DATA_W-1:0]   smax;
   } item_type;

   typedef struct packed {
      logic [DATA_W-1:0] full_scale;
      logic              invert;
   } cfg_type;

endpackage

`default_nettype wire

[src/smcn_ram.sv]
//------------------------------------------------------------------------------
// smcn_ram
// Generic single-write, single-read RAM with registered read data.
//------------------------------------------------------------------------------
`default_nettype none

module smcn_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 15
) (
   input  wire logic                                          clock,
   input  wire logic                                          wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
   input  wire logic [WIDTH-1:0]                              wr_data,
   input  wire logic                                          rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
   output      logic [WIDTH-1:0]                              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[src/smcn_front.sv]
//------------------------------------------------------------------------------
// smcn_front
// Command intake: classifies each word and holds it in a short queue.
//------------------------------------------------------------------------------
`default_nettype none

module smcn_front #(
   parameter int CHANNELS = 15
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output      logic                          busy,
   input  wire logic [1:0]                    req_operation,
   input  wire logic [smcn_pkg::CH_W-1:0]     req_channel,
   input  wire logic [smcn_pkg::DATA_W-1:0]   req_raw_value,
   input  wire logic [smcn_pkg::DATA_W-1:0]   req_stored_minimum,
   input  wire logic [smcn_pkg::DATA_W-1:0]   req_stored_maximum,
   input  wire logic                          pop,
   output      logic                          head_valid,
   output      smcn_pkg::item_type            head
);

   localparam int PW = (smcn_pkg::QUEUE_DEPTH > 1) ? $clog2(smcn_pkg::QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(smcn_pkg::QUEUE_DEPTH + 1);

   smcn_pkg::item_type queue_ff [smcn_pkg::QUEUE_DEPTH];
   smcn_pkg::item_type new_item;
   logic [PW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]      count_ff, count_in;
   logic               push;

   assign busy       = (count_ff == CW'(smcn_pkg::QUEUE_DEPTH));
   assign push       = start & ~busy;
   assign head_valid = (count_ff != '0);
   assign head       = queue_ff[rd_ptr_ff];

   always_comb begin
      new_item.op      = smcn_pkg::op_type'(req_operation);
      new_item.ch_ok   = (32'(req_channel) < CHANNELS);
      new_item.channel = req_channel;
      new_item.raw     = req_raw_value;
      new_item.smin    = req_stored_minimum;
      new_item.smax    = req_stored_maximum;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(smcn_pkg::QUEUE_DEPTH - 1)) ? '0 : PW'(wr_ptr_ff + 1'b1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(smcn_pkg::QUEUE_DEPTH - 1)) ? '0 : PW'(rd_ptr_ff + 1'b1);
      end
      count_in = CW'(count_ff + CW'(push) - CW'(pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

`default_nettype wire

[src/smcn_back.sv]
//------------------------------------------------------------------------------
// smcn_back
// Executes queued words: extreme tracking, loads, clears and normalization
// with a one-bit-per-cycle restoring divider.
//------------------------------------------------------------------------------
`default_nettype none

module smcn_back #(
   parameter int CHANNELS = 15
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire smcn_pkg::cfg_type             cfg,
   input  wire logic                          head_valid,
   input  wire smcn_pkg::item_type            head,
   output      logic                          pop,
   output      logic                          rsp_valid,
   output      logic [smcn_pkg::DATA_W-1:0]   rsp_normalized_value,
   output      logic [smcn_pkg::CH_W-1:0]     rsp_result_channel
);

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int DW    = smcn_pkg::DATA_W;

   smcn_pkg::state_type st_ff, st_in;
   smcn_pkg::item_type  cur_ff, cur_in;
   smcn_pkg::kind_type  kind_ff, kind_in;
   logic [CHANNELS-1:0] vld_ff, vld_in;
   logic [DW-1:0]       range_ff, range_in;
   logic [DW-1:0]       diff_ff, diff_in;
   logic [DW-1:0]       rem_ff, rem_in;
   logic [DW-1:0]       quo_ff, quo_in;
   logic [3:0]          cnt_ff, cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0]       rsp_value_ff, rsp_value_in;
   logic [smcn_pkg::CH_W-1:0] rsp_ch_ff, rsp_ch_in;

   logic                      ram_wr_en, ram_rd_en;
   logic [IDX_W-1:0]          ram_wr_addr, ram_rd_addr;
   logic [smcn_pkg::PAIR_W-1:0] ram_wr_data, ram_rd_data;

   logic [IDX_W-1:0] head_idx, cur_idx;
   logic [DW-1:0]    lo, hi, new_lo, new_hi, rng;
   logic [DW:0]      dif, step_t, step_sub;
   logic             step_ge;
   logic [31:0]      prod;
   logic [DW-1:0]    q_sat;

   assign head_idx = IDX_W'(head.channel);
   assign cur_idx  = IDX_W'(cur_ff.channel);

   // entry not written since clear reads as the reset extremes
   assign lo     = vld_ff[cur_idx] ? ram_rd_data[DW-1:0] : smcn_pkg::MIN_RESET;
   assign hi     = vld_ff[cur_idx] ? ram_rd_data[2*DW-1:DW] : smcn_pkg::MAX_RESET;
   assign new_lo = (cur_ff.raw < lo) ? cur_ff.raw : lo;
   assign new_hi = (cur_ff.raw > hi) ? cur_ff.raw : hi;
   assign rng    = DW'(hi - lo);
   assign dif    = {1'b0, cur_ff.raw} - {1'b0, lo};

   assign prod     = 32'(diff_ff) * 32'(cfg.full_scale);
   assign step_t   = {rem_ff, quo_ff[DW-1]};
   assign step_ge  = (step_t >= {1'b0, range_ff});
   assign step_sub = step_t - {1'b0, range_ff};

   always_comb begin
      case (kind_ff)
         smcn_pkg::KIND_HIGH: q_sat = cfg.full_scale;
         smcn_pkg::KIND_DIV:  q_sat = quo_ff;
         default:             q_sat = '0;
      endcase
   end

   always_comb begin
      st_in        = st_ff;
      cur_in       = cur_ff;
      kind_in      = kind_ff;
      vld_in       = vld_ff;
      range_in     = range_ff;
      diff_in      = diff_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = 1'b0;
      rsp_value_in = rsp_value_ff;
      rsp_ch_in    = rsp_ch_ff;
      pop          = 1'b0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = head_idx;
      ram_wr_data  = {head.smax, head.smin};
      ram_rd_en    = 1'b0;
      ram_rd_addr  = head_idx;

      case (st_ff)
         smcn_pkg::S_IDLE: begin
            if (head_valid) begin
               pop    = 1'b1;
               cur_in = head;
               case (head.op)
                  smcn_pkg::OP_CLEAR: begin
                     vld_in = '0;
                  end
                  smcn_pkg::OP_LOAD: begin
                     if (head.ch_ok) begin
                        ram_wr_en        = 1'b1;
                        vld_in[head_idx] = 1'b1;
                     end
                  end
                  smcn_pkg::OP_TRACK: begin
                     if (head.ch_ok) begin
                        ram_rd_en = 1'b1;
                        st_in     = smcn_pkg::S_READ;
                     end
                  end
                  smcn_pkg::OP_NORM: begin
                     if (head.ch_ok) begin
                        ram_rd_en = 1'b1;
                        st_in     = smcn_pkg::S_READ;
                     end else begin
                        kind_in = smcn_pkg::KIND_ZERO;
                        st_in   = smcn_pkg::S_DONE;
                     end
                  end
                  default: begin
                     st_in = smcn_pkg::S_IDLE;
                  end
               endcase
            end
         end
         smcn_pkg::S_READ: begin
            if (cur_ff.op == smcn_pkg::OP_TRACK) begin
               ram_wr_en       = 1'b1;
               ram_wr_addr     = cur_idx;
               ram_wr_data     = {new_hi, new_lo};
               vld_in[cur_idx] = 1'b1;
               st_in           = smcn_pkg::S_IDLE;
            end else begin
               range_in = rng;
               diff_in  = dif[DW-1:0];
               if (rng == '0) begin
                  kind_in = smcn_pkg::KIND_ZERO;
                  st_in   = smcn_pkg::S_DONE;
               end else if (dif[DW]) begin
                  kind_in = smcn_pkg::KIND_LOW;
                  st_in   = smcn_pkg::S_DONE;
               end else if (dif[DW-1:0] > rng) begin
                  // quotient is at least full scale, saturates
                  kind_in = smcn_pkg::KIND_HIGH;
                  st_in   = smcn_pkg::S_DONE;
               end else begin
                  kind_in = smcn_pkg::KIND_DIV;
                  st_in   = smcn_pkg::S_MUL;
               end
            end
         end
         smcn_pkg::S_MUL: begin
            // diff <= range keeps the upper half below range
            rem_in = prod[31:16];
            quo_in = prod[15:0];
            cnt_in = '0;
            st_in  = smcn_pkg::S_DIV;
         end
         smcn_pkg::S_DIV: begin
            rem_in = step_ge ? step_sub[DW-1:0] : step_t[DW-1:0];
            quo_in = {quo_ff[DW-2:0], step_ge};
            cnt_in = 4'(cnt_ff + 1'b1);
            if (cnt_ff == 4'(DW - 1)) begin
               st_in = smcn_pkg::S_DONE;
            end
         end
         smcn_pkg::S_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_ch_in    = cur_ff.channel;
            if (kind_ff != smcn_pkg::KIND_ZERO && cfg.invert) begin
               rsp_value_in = DW'(cfg.full_scale - q_sat);
            end else begin
               rsp_value_in = q_sat;
            end
            st_in = smcn_pkg::S_IDLE;
         end
         default: begin
            st_in = smcn_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= smcn_pkg::S_IDLE;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      kind_ff      <= kind_in;
      range_ff     <= range_in;
      diff_ff      <= diff_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      cnt_ff       <= cnt_in;
      rsp_value_ff <= rsp_value_in;
      rsp_ch_ff    <= rsp_ch_in;
   end

   smcn_ram #(
      .WIDTH (smcn_pkg::PAIR_W),
      .DEPTH (CHANNELS)
   ) u_ext_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_normalized_value = rsp_value_ff;
   assign rsp_result_channel   = rsp_ch_ff;

   a_done_strobe: assert property (@(posedge clock) disable iff (reset)
      st_ff == smcn_pkg::S_DONE |=> rsp_valid_ff)
      else $error("result strobe missing after done");

   a_result_bound: assert property (@(posedge clock) disable iff (reset)
      st_ff == smcn_pkg::S_DONE |-> rsp_value_in <= cfg.full_scale)
      else $error("normalized value above full scale");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      st_ff == smcn_pkg::S_DIV |-> rem_ff < range_ff)
      else $error("divider remainder not below range");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid && st_ff == smcn_pkg::S_IDLE)
      else $error("queue popped while back end busy or queue empty");

endmodule

`default_nettype wire

[src/sensor_minmax_calibrate_normalize_top.sv]
//------------------------------------------------------------------------------
// sensor_minmax_calibrate_normalize_top
// Per-channel min/max calibration and normalization for a sensor array.
//------------------------------------------------------------------------------
// Commands enter on start while busy is low and wait in a two-word queue;
// busy rises only when that queue is full. The back end runs one command at
// a time: clear and load complete on pop, track reads then writes the extreme
// RAM, and a normalize needing a division runs the RAM read, classify,
// multiply, 16 serial divider steps and result, or skips multiply and divider
// when the range is zero or the reading lies outside the calibrated span. The
// divider sets the sustained rate of normalize commands. The result appears
// for one cycle with rsp_valid and must be taken then. Clear resets all
// channels at once through per-channel valid bits, so no sweep follows reset.
//------------------------------------------------------------------------------
`default_nettype none

module sensor_minmax_calibrate_normalize_top #(
   parameter int CHANNELS = 15
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output      logic                               busy,
   input  wire logic [1:0]                         req_operation,
   input  wire logic [smcn_pkg::CH_W-1:0]          req_channel,
   input  wire logic [smcn_pkg::DATA_W-1:0]        req_raw_value,
   input  wire logic [smcn_pkg::DATA_W-1:0]        req_stored_minimum,
   input  wire logic [smcn_pkg::DATA_W-1:0]        req_stored_maximum,
   output      logic                               rsp_valid,
   output      logic [smcn_pkg::DATA_W-1:0]        rsp_normalized_value,
   output      logic [smcn_pkg::CH_W-1:0]          rsp_result_channel,
   input  wire logic                               csr_valid,
   output      logic                               csr_ready,
   input  wire logic [smcn_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [smcn_pkg::DATA_W-1:0]        csr_data
);

   smcn_pkg::cfg_type  cfg_ff, cfg_in;
   smcn_pkg::item_type head;
   logic               head_valid;
   logic               pop;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            smcn_pkg::CSR_FULL_SCALE: cfg_in.full_scale = csr_data;
            smcn_pkg::CSR_INVERT:     cfg_in.invert     = csr_data[0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.full_scale <= smcn_pkg::FULL_SCALE_RESET;
         cfg_ff.invert     <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   smcn_front #(
      .CHANNELS (CHANNELS)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_operation      (req_operation),
      .req_channel        (req_channel),
      .req_raw_value      (req_raw_value),
      .req_stored_minimum (req_stored_minimum),
      .req_stored_maximum (req_stored_maximum),
      .pop                (pop),
      .head_valid         (head_valid),
      .head               (head)
   );

   smcn_back #(
      .CHANNELS (CHANNELS)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .cfg                  (cfg_ff),
      .head_valid           (head_valid),
      .head                 (head),
      .pop                  (pop),
      .rsp_valid            (rsp_valid),
      .rsp_normalized_value (rsp_normalized_value),
      .rsp_result_channel   (rsp_result_channel)
   );

endmodule

`default_nettype wire

[verif/sensor_minmax_calibrate_normalize_top_tb.sv]
//------------------------------------------------------------------------------
// sensor_minmax_calibrate_normalize_top_tb
// Drives calibration commands into the min/max sensor block and compares
// every normalized reading against a behavioral copy of the per-channel
// extremes and the two control registers. Directed corner cases come first,
// then three phases of randomized calibration traffic, the last with no gaps.
//------------------------------------------------------------------------------
module sensor_minmax_calibrate_normalize_top_tb;

   localparam int NUM_CH       = 15;
   localparam int DRAIN_CYCLES = 80;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int CHUNK_WORDS  = 130;
   localparam int PRINT_CAP    = 40;

   typedef logic [smcn_pkg::DATA_W-1:0]      word_type;
   typedef logic [smcn_pkg::CH_W-1:0]        chan_type;
   typedef logic [smcn_pkg::CSR_INDEX_W-1:0] csr_index_type;

   // indexes beyond the register list, written to show they are ignored
   localparam csr_index_type CSR_SPARE_A = 2'd2;
   localparam csr_index_type CSR_SPARE_B = 2'd3;

   typedef struct {
      word_type value;
      chan_type channel;
   } reading_type;

   logic          clock;
   logic          reset;
   logic          start;
   logic          busy;
   logic [1:0]    req_operation;
   chan_type      req_channel;
   word_type      req_raw_value;
   word_type      req_stored_minimum;
   word_type      req_stored_maximum;
   logic          rsp_valid;
   word_type      rsp_normalized_value;
   chan_type      rsp_result_channel;
   logic          csr_valid;
   logic          csr_ready;
   csr_index_type csr_index;
   word_type      csr_data;

   // predicted calibration state
   word_type cal_min [NUM_CH];
   word_type cal_max [NUM_CH];
   word_type cfg_full_scale;
   logic     cfg_invert;

   reading_type pending_readings [$];
   reading_type oldest_reading;
   int          mismatch_count  = 0;
   int          cycle_count     = 0;
   int          sender_idle_pct = 37;

   sensor_minmax_calibrate_normalize_top #(
      .CHANNELS(NUM_CH)
   ) DUT (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_operation        (req_operation),
      .req_channel          (req_channel),
      .req_raw_value        (req_raw_value),
      .req_stored_minimum   (req_stored_minimum),
      .req_stored_maximum   (req_stored_maximum),
      .rsp_valid            (rsp_valid),
      .rsp_normalized_value (rsp_normalized_value),
      .rsp_result_channel   (rsp_result_channel),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   //---------------------------------------------------------------------------
   // prediction
   //---------------------------------------------------------------------------
   function automatic word_type scaled_reading(word_type raw, word_type lo, word_type hi);
      word_type span;
      longint   diff;
      longint   q;
      span = hi - lo;
      if (span == '0) begin
         return '0;
      end
      diff = longint'({48'd0, raw}) - longint'({48'd0, lo});
      q = (diff * longint'({48'd0, cfg_full_scale})) / longint'({48'd0, span});
      if (q < 0) begin
         q = 0;
      end
      if (q > longint'({48'd0, cfg_full_scale})) begin
         q = longint'({48'd0, cfg_full_scale});
      end
      if (cfg_invert) begin
         q = longint'({48'd0, cfg_full_scale}) - q;
      end
      return q[smcn_pkg::DATA_W-1:0];
   endfunction

   task automatic clear_calibration();
      for (int i = 0; i < NUM_CH; i++) begin
         cal_min[i] = smcn_pkg::MIN_RESET;
         cal_max[i] = smcn_pkg::MAX_RESET;
      end
   endtask

   task automatic note_word(smcn_pkg::op_type op, chan_type ch, word_type raw,
                            word_type smin, word_type smax);
      reading_type r;
      case (op)
         smcn_pkg::OP_CLEAR: begin
            clear_calibration();
         end
         smcn_pkg::OP_TRACK: begin
            if (ch < NUM_CH) begin
               if (raw < cal_min[ch]) cal_min[ch] = raw;
               if (raw > cal_max[ch]) cal_max[ch] = raw;
            end
         end
         smcn_pkg::OP_NORM: begin
            r.value   = (ch < NUM_CH) ? scaled_reading(raw, cal_min[ch], cal_max[ch]) : '0;
            r.channel = ch;
            pending_readings.push_back(r);
         end
         default: begin
            if (ch < NUM_CH) begin
               cal_min[ch] = smin;
               cal_max[ch] = smax;
            end
         end
      endcase
   endtask

   //---------------------------------------------------------------------------
   // checking
   //---------------------------------------------------------------------------
   task automatic report_mismatch(string what, word_type got, word_type want);
      if (mismatch_count < PRINT_CAP) begin
         $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
      end
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_readings.size() == 0) begin
            report_mismatch("unexpected reading", rsp_normalized_value, '0);
         end else begin
            oldest_reading = pending_readings.pop_front();
            if (rsp_normalized_value !== oldest_reading.value) begin
               report_mismatch("normalized_value", rsp_normalized_value, oldest_reading.value);
            end
            if (rsp_result_channel !== oldest_reading.channel) begin
               report_mismatch("result_channel", word_type'(rsp_result_channel),
                               word_type'(oldest_reading.channel));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   //---------------------------------------------------------------------------
   // driving
   //---------------------------------------------------------------------------
   function automatic word_type rand_word();
      return word_type'($urandom);
   endfunction

   function automatic chan_type rand_chan();
      return chan_type'($urandom_range(15));
   endfunction

   task automatic pause_sender();
      while ($urandom_range(99) < sender_idle_pct) begin
         @(negedge clock);
         start              = 1'b0;
         req_operation      = 2'($urandom_range(3));
         req_channel        = rand_chan();
         req_raw_value      = rand_word();
         req_stored_minimum = rand_word();
         req_stored_maximum = rand_word();
         @(posedge clock);
      end
   endtask

   task automatic send_word(smcn_pkg::op_type op, chan_type ch, word_type raw,
                            word_type smin, word_type smax);
      pause_sender();
      @(negedge clock);
      start              = 1'b1;
      req_operation      = op;
      req_channel        = ch;
      req_raw_value      = raw;
      req_stored_minimum = smin;
      req_stored_maximum = smax;
      @(posedge clock);
      while (busy) @(posedge clock);
      note_word(op, ch, raw, smin, smax);
   endtask

   // stop sending and let every pending reading and queued word finish
   task automatic drain_block();
      @(negedge clock);
      start = 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(csr_index_type index, word_type data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = index;
      csr_data  = data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (index == smcn_pkg::CSR_FULL_SCALE) begin
         cfg_full_scale = data;
      end else if (index == smcn_pkg::CSR_INVERT) begin
         cfg_invert = data[0];
      end
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic word_type pick_value();
      int r;
      r = $urandom_range(9);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return rand_word();
   endfunction

   // mostly readings inside the calibrated span of the channel
   function automatic word_type pick_reading(chan_type ch);
      if (ch < NUM_CH && cal_min[ch] <= cal_max[ch] && $urandom_range(3) != 0) begin
         return word_type'($urandom_range(int'(cal_max[ch]), int'(cal_min[ch])));
      end
      return pick_value();
   endfunction

   //---------------------------------------------------------------------------
   // tests
   //---------------------------------------------------------------------------
   task automatic test_reset_state();
      // minimum above maximum after reset, span wraps to one
      send_word(smcn_pkg::OP_NORM, 4'd0, 16'd0, rand_word(), rand_word());
      send_word(smcn_pkg::OP_NORM, 4'd14, 16'hFFFF, rand_word(), rand_word());
   endtask

   task automatic test_loaded_span();
      send_word(smcn_pkg::OP_LOAD, 4'd0, rand_word(), 16'd100, 16'd1100);
      send_word(smcn_pkg::OP_NORM, 4'd0, 16'd600, rand_word(), rand_word());
      send_word(smcn_pkg::OP_NORM, 4'd0, 16'd50, rand_word(), rand_word());
      send_word(smcn_pkg::OP_NORM, 4'd0, 16'd2000, rand_word(), rand_word());
      send_word(smcn_pkg::OP_NORM, 4'd0, 16'd100, rand_word(), rand_word());
      send_word(smcn_pkg::OP_NORM, 4'd0, 16'd1100, rand_word(), rand_word());
   endtask

   task automatic test_flat_and_wrapped_span();
      send_word(smcn_pkg::OP_LOAD, 4'd5, rand_word(), 16'd777, 16'd777);
      send_word(smcn_pkg::OP_NORM, 4'd5, 16'd777, rand_word(), rand_word());
      send_word(smcn_pkg::OP_LOAD, 4'd6, rand_word(), 16'd60000, 16'd100);
      send_word(smcn_pkg::OP_NORM, 4'd6, 16'd30000, rand_word(), rand_word());
   endtask

   task automatic test_tracking_and_clear();
      send_word(smcn_pkg::OP_TRACK, 4'd3, 16'd0, rand_word(), rand_word());
      send_word(smcn_pkg::OP_TRACK, 4'd3, 16'hFFFF, rand_word(), rand_word());
      send_word(smcn_pkg::OP_NORM, 4'd3, 16'd32768, rand_word(), rand_word());
      send_word(smcn_pkg::OP_CLEAR, 4'd3, rand_word(), rand_word(), rand_word());
      send_word(smcn_pkg::OP_NORM, 4'd3, 16'd32768, rand_word(), rand_word());
   endtask

   task automatic test_unused_channel();
      send_word(smcn_pkg::OP_LOAD, 4'd15, rand_word(), 16'd0, 16'd10);
      send_word(smcn_pkg::OP_TRACK, 4'd15, 16'd5, rand_word(), rand_word());
      send_word(smcn_pkg::OP_NORM, 4'd15, 16'hFFFF, rand_word(), rand_word());
   endtask

   task automatic test_register_extremes();
      drain_block();
      write_register(smcn_pkg::CSR_FULL_SCALE, 16'hFFFF);
      write_register(smcn_pkg::CSR_INVERT, 16'd1);
      send_word(smcn_pkg::OP_LOAD, 4'd14, rand_word(), 16'd0, 16'hFFFF);
      send_word(smcn_pkg::OP_NORM, 4'd14, 16'hFFFF, rand_word(), rand_word());
      send_word(smcn_pkg::OP_NORM, 4'd14, 16'd0, rand_word(), rand_word());
      drain_block();
      // zero full scale saturates everything to zero
      write_register(smcn_pkg::CSR_FULL_SCALE, 16'd0);
      send_word(smcn_pkg::OP_NORM, 4'd14, 16'd1234, rand_word(), rand_word());
      drain_block();
      write_register(smcn_pkg::CSR_FULL_SCALE, 16'd1);
      write_register(smcn_pkg::CSR_INVERT, 16'd0);
      write_register(CSR_SPARE_A, rand_word());
      write_register(CSR_SPARE_B, rand_word());
      send_word(smcn_pkg::OP_NORM, 4'd14, 16'hFFFF, rand_word(), rand_word());
   endtask

   task automatic pick_registers();
      word_type fs;
      case ($urandom_range(4))
         0:       fs = 16'd1;
         1:       fs = 16'hFFFF;
         2:       fs = word_type'($urandom_range(2000, 1));
         default: fs = word_type'($urandom_range(65535, 1));
      endcase
      write_register(smcn_pkg::CSR_FULL_SCALE, fs);
      write_register(smcn_pkg::CSR_INVERT, rand_word());
      if ($urandom_range(3) == 0) begin
         write_register(CSR_SPARE_B, rand_word());
      end
   endtask

   task automatic random_chunk(int words);
      int       sent;
      int       r;
      int       n;
      chan_type ch;
      word_type lo;
      word_type hi;
      word_type t;
      sent = 0;
      while (sent < words) begin
         r  = $urandom_range(99);
         ch = rand_chan();
         if (r < 70) begin
            // calibrate one channel, then read it back
            if ($urandom_range(3) == 0) begin
               lo = pick_value();
               hi = pick_value();
               if (lo > hi && $urandom_range(4) != 0) begin
                  t  = lo;
                  lo = hi;
                  hi = t;
               end
               send_word(smcn_pkg::OP_LOAD, ch, rand_word(), lo, hi);
               sent++;
            end else begin
               n = $urandom_range(5, 1);
               repeat (n) begin
                  send_word(smcn_pkg::OP_TRACK, ch, pick_value(), rand_word(), rand_word());
               end
               sent += n;
            end
            n = $urandom_range(3, 1);
            repeat (n) begin
               send_word(smcn_pkg::OP_NORM, ch, pick_reading(ch), rand_word(), rand_word());
            end
            sent += n;
         end else if (r < 74) begin
            send_word(smcn_pkg::OP_CLEAR, ch, rand_word(), rand_word(), rand_word());
            sent++;
         end else begin
            send_word(smcn_pkg::op_type'($urandom_range(3)), ch, pick_value(), pick_value(),
                      pick_value());
            sent++;
         end
      end
   endtask

   task automatic test_random_traffic(int idle_pct);
      sender_idle_pct = idle_pct;
      repeat (5) begin
         drain_block();
         pick_registers();
         random_chunk(CHUNK_WORDS);
      end
   endtask

   initial begin
      reset              = 1'b1;
      start              = 1'b0;
      req_operation      = '0;
      req_channel        = '0;
      req_raw_value      = '0;
      req_stored_minimum = '0;
      req_stored_maximum = '0;
      csr_valid          = 1'b0;
      csr_index          = '0;
      csr_data           = '0;
      cfg_full_scale     = smcn_pkg::FULL_SCALE_RESET;
      cfg_invert         = 1'b0;
      clear_calibration();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_state();
      test_loaded_span();
      test_flat_and_wrapped_span();
      test_tracking_and_clear();
      test_unused_channel();
      test_register_extremes();
      test_random_traffic(37);
      test_random_traffic(60);
      test_random_traffic(0);
      drain_block();

      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
